// ----- hdl/http_chunked_body_decoder_macros.svh -----
// Assertion helpers for the chunked body decoder.
// Both expect clk and arst_n in scope.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication
`define HCBD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcbd check failed");

// next-cycle implication
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcbd check failed");

`endif

// ----- hdl/hcbd_pkg.sv -----
package hcbd_pkg;

	localparam int MAX_SIZE_DIGITS = 16;
	localparam int LEN_LIMIT       = MAX_SIZE_DIGITS + 1;
	localparam int LEN_W           = 5;
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = 2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HI = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef enum logic [3:0] {
		ST_BUSY       = 4'd0,
		ST_DONE       = 4'd1,
		ST_NO_SIZE    = 4'd2,
		ST_EMPTY      = 4'd3,
		ST_TOO_LONG   = 4'd4,
		ST_BAD_HEX    = 4'd5,
		ST_PAST_END   = 4'd6,
		ST_NO_TERM    = 4'd7,
		ST_NO_TRAILER = 4'd8
	} status_t;

	typedef enum logic [5:0] {
		PH_SIZE       = 6'b000001,
		PH_DATA       = 6'b000010,
		PH_AFTER_DATA = 6'b000100,
		PH_AFTER_CR   = 6'b001000,
		PH_TRAILER    = 6'b010000,
		PH_SKIP       = 6'b100000
	} phase_t;

	// classified input beat
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_cr;
		logic       is_lf;
		logic       is_semi;
		logic       is_blank;
		logic       is_hex;
		logic [3:0] hex_val;
	} cls_t;

endpackage

// ----- hdl/http_chunked_body_decoder.sv -----
// Chunked body decoder: one input beat per body byte, one result beat per input beat.
// Input channel: in_valid / in_stall with in_byte and last_of_input; a beat is taken
// when in_valid is high and in_stall low. last_of_input marks the final byte of a body.
// Output channel: out_valid / out_stall with payload_byte, payload_valid and status.
// payload_valid flags chunk data (payload_byte is zero otherwise); status reports done,
// an error code, or zero while busy or skipping after an end.
// Throughput: one beat per cycle while out_stall is low, set by the back end's step
// (a 64-bit shift-in of a hex digit or a 64-bit decrement of the chunk count).
// Path: a taken beat is written into the queue, then popped into the output register
// once the output side is free.
// Structure: a front end classifies each byte (CR, LF, ';', blank, hex digit) and
// pushes it into a four-entry queue; the back end pops it, steps the parse state and
// loads the output register. in_stall rises only when the queue is full, so the
// input keeps flowing until the queue holds four beats while the receiver stalls.
// Reset (arst_n low) clears the queue, the output valid and the parse state, which
// starts at the beginning of a size line. No clearing pass is needed.
module http_chunked_body_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic [3:0] status
);
	import hcbd_pkg::*;

	cls_t front_item;
	cls_t back_item;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	// classify and admit
	hcbd_front u_front (
		.in_valid      (in_valid),
		.in_byte       (in_byte),
		.last_of_input (last_of_input),
		.q_full        (q_full),
		.in_stall      (in_stall),
		.push          (push),
		.item          (front_item)
	);

	// decouples input acceptance from output stalls
	hcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (front_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_item   (back_item)
	);

	// parse state machine and result register
	hcbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.item          (back_item),
		.out_stall     (out_stall),
		.pop           (pop),
		.out_valid     (out_valid),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.status        (status)
	);

endmodule

// ----- hdl/hcbd_front.sv -----
module hcbd_front (
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               last_of_input,
	input  logic               q_full,
	output logic               in_stall,
	output logic               push,
	output hcbd_pkg::cls_t     item
);
	import hcbd_pkg::*;

	logic [7:0] hv;

	always_comb begin
		hv = 8'd0;
		item.is_hex = 1'b1;
		if (in_byte >= CH_0 && in_byte <= CH_9) begin
			hv = in_byte - CH_0;
		end else if (in_byte >= CH_LA && in_byte <= CH_LF_HI) begin
			hv = in_byte - CH_LA + HEX_TEN;
		end else if (in_byte >= CH_UA && in_byte <= CH_UF) begin
			hv = in_byte - CH_UA + HEX_TEN;
		end else begin
			item.is_hex = 1'b0;
		end
		item.hex_val  = hv[3:0];
		item.data     = in_byte;
		item.last     = last_of_input;
		item.is_cr    = (in_byte == CH_CR);
		item.is_lf    = (in_byte == CH_LF);
		item.is_semi  = (in_byte == CH_SEMI);
		item.is_blank = (in_byte == CH_SP) || (in_byte == CH_TAB);
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

// ----- hdl/hcbd_queue.sv -----
module hcbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcbd_pkg::cls_t wr_item,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output hcbd_pkg::cls_t rd_item
);
	import hcbd_pkg::*;

	cls_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/hcbd_back.sv -----
module hcbd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  hcbd_pkg::cls_t item,
	input  logic           out_stall,
	output logic           pop,
	output logic           out_valid,
	output logic [7:0]     payload_byte,
	output logic           payload_valid,
	output logic [3:0]     status
);
	import hcbd_pkg::*;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] tb;
		logic             bad;
		logic             ext;
		logic             sh;
	} sz_t;

	// one size-line character; sh marks a hex digit to shift in
	function automatic sz_t size_step(sz_t s, logic semi, logic blank, logic hex);
		sz_t           r;
		logic [LEN_W:0] sum;
		r    = s;
		r.sh = 1'b0;
		sum  = {1'b0, s.len} + {1'b0, s.tb};
		if (s.ext) begin
			r.ext = 1'b1;
		end else if (semi) begin
			r.ext = 1'b1;
		end else if (blank) begin
			if (s.len != '0 && s.tb < LEN_W'(LEN_LIMIT)) r.tb = s.tb + 1'b1;
		end else begin
			if (s.tb != '0) begin
				r.len = (sum > (LEN_W+1)'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : sum[LEN_W-1:0];
				r.tb  = '0;
				r.bad = 1'b1;
			end
			if (r.len < LEN_W'(LEN_LIMIT)) r.len = r.len + 1'b1;
			if (!hex)          r.bad = 1'b1;
			else if (!r.bad)   r.sh  = 1'b1;
		end
		return r;
	endfunction

	function automatic status_t end_code(phase_t ph);
		status_t c;
		unique case (ph) inside
			PH_SIZE:                  c = ST_NO_SIZE;
			PH_DATA:                  c = ST_PAST_END;
			PH_AFTER_DATA, PH_AFTER_CR: c = ST_NO_TERM;
			PH_TRAILER:               c = ST_NO_TRAILER;
			default:                  c = ST_BUSY;
		endcase
		return c;
	endfunction

	phase_t           ph_q,  ph_d;
	logic [63:0]      rem_q, rem_d;
	logic [63:0]      acc_q, acc_d;
	logic [LEN_W-1:0] len_q, tb_q;
	logic             bad_q, ext_q, hcr_q, hcr_d;
	logic [1:0]       tl_q,  tl_d;
	sz_t              sc;
	logic             eol_seen;
	status_t          st;
	logic [7:0]       pb;
	logic             pv;

	logic             out_valid_q;
	logic [7:0]       pbyte_q;
	logic             pvalid_q;
	status_t          status_q;

	assign pop = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		ph_d     = ph_q;
		rem_d    = rem_q;
		acc_d    = acc_q;
		hcr_d    = hcr_q;
		tl_d     = tl_q;
		sc       = '{len: len_q, tb: tb_q, bad: bad_q, ext: ext_q, sh: 1'b0};
		eol_seen = 1'b0;
		st       = ST_BUSY;
		pb       = 8'd0;
		pv       = 1'b0;
		unique case (ph_q)
			PH_SIZE: begin
				if (hcr_q && item.is_lf) begin
					eol_seen = 1'b1;
				end else begin
					hcr_d = 1'b0;
					// held CR not followed by LF is an ordinary, non-hex char
					if (hcr_q) sc = size_step(sc, 1'b0, 1'b0, 1'b0);
					if (item.is_cr) begin
						hcr_d = 1'b1;
					end else if (item.is_lf) begin
						eol_seen = 1'b1;
					end else begin
						sc = size_step(sc, item.is_semi, item.is_blank, item.is_hex);
						if (sc.sh) acc_d = {acc_q[59:0], item.hex_val};
					end
				end
				if (eol_seen) begin
					if (sc.len == '0)                         st = ST_EMPTY;
					else if (sc.len > LEN_W'(MAX_SIZE_DIGITS)) st = ST_TOO_LONG;
					else if (sc.bad)                          st = ST_BAD_HEX;
					else if (acc_q == 64'd0) begin
						ph_d = PH_TRAILER;
						tl_d = 2'd0;
					end else begin
						ph_d  = PH_DATA;
						rem_d = acc_q;
					end
					acc_d = 64'd0;
					sc    = '0;
					hcr_d = 1'b0;
				end
			end
			PH_DATA: begin
				pb    = item.data;
				pv    = 1'b1;
				rem_d = rem_q - 64'd1;
				if (rem_q == 64'd1) ph_d = PH_AFTER_DATA;
			end
			PH_AFTER_DATA: begin
				if (item.is_cr)      ph_d = PH_AFTER_CR;
				else if (item.is_lf) ph_d = PH_SIZE;
				else                 st   = ST_NO_TERM;
			end
			PH_AFTER_CR: begin
				if (item.is_lf) ph_d = PH_SIZE;
				else            st   = ST_NO_TERM;
			end
			PH_TRAILER: begin
				if (item.is_lf) begin
					if (tl_q <= 2'd1) st = ST_DONE;
					tl_d = 2'd0;
				end else if (item.is_cr && tl_q == 2'd0) begin
					tl_d = 2'd1;
				end else begin
					tl_d = 2'd2;
				end
			end
			default: begin
			end
		endcase

		if (st == ST_BUSY && item.last) st = end_code(ph_d);
		if (item.last) begin
			ph_d  = PH_SIZE;
			rem_d = 64'd0;
			acc_d = 64'd0;
			sc    = '0;
			hcr_d = 1'b0;
			tl_d  = 2'd0;
		end else if (st != ST_BUSY) begin
			ph_d = PH_SKIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_SIZE;
			rem_q <= 64'd0;
			acc_q <= 64'd0;
			len_q <= '0;
			tb_q  <= '0;
			bad_q <= 1'b0;
			ext_q <= 1'b0;
			hcr_q <= 1'b0;
			tl_q  <= 2'd0;
		end else if (pop) begin
			ph_q  <= ph_d;
			rem_q <= rem_d;
			acc_q <= acc_d;
			len_q <= sc.len;
			tb_q  <= sc.tb;
			bad_q <= sc.bad;
			ext_q <= sc.ext;
			hcr_q <= hcr_d;
			tl_q  <= tl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pbyte_q  <= pb;
			pvalid_q <= pv;
			status_q <= st;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = pbyte_q;
	assign payload_valid = pvalid_q;
	assign status        = status_q;

endmodule

// ----- hdl/hcbd_checker.sv -----
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic [3:0] status
);
	import hcbd_pkg::*;

	// end-of-input codes a data beat may carry
	logic data_end_code;
	assign data_end_code = (status == ST_PAST_END) || (status == ST_NO_TERM);

	// data beats only carry busy, past-end or, on the chunk's final byte, no-terminator
	`HCBD_ASSERT_NOW(a_data_status, out_valid && payload_valid, status == ST_BUSY || data_end_code)
	// non-data beats carry a zero byte
	`HCBD_ASSERT_NOW(a_idle_byte, out_valid && !payload_valid, payload_byte == 8'd0)
	// status stays within the defined codes
	`HCBD_ASSERT_NOW(a_status_range, out_valid, status <= ST_NO_TRAILER)
	// stalled result beat is held
	`HCBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

// ----- dv/chunk_scoreboard_pkg.sv -----
package chunk_scoreboard_pkg;

	import hcbd_pkg::*;

	// Tracks the decoder's parse state per accepted input beat and holds the
	// result beats that the block owes, oldest first.
	class chunk_scoreboard;

		typedef struct packed {
			logic [7:0] pbyte;
			logic       pvalid;
			status_t    st;
		} beat_t;

		beat_t       owed_q[$];
		int          errors;

		phase_t      ph;
		logic [63:0] remaining;
		logic [63:0] accum;
		int          digits;
		int          blanks;
		bit          bad;
		bit          in_ext;
		bit          cr_held;
		int          trailer_len;

		function new();
			errors = 0;
			restart();
		endfunction

		function void clear_line();
			accum   = '0;
			digits  = 0;
			blanks  = 0;
			bad     = 1'b0;
			in_ext  = 1'b0;
			cr_held = 1'b0;
		endfunction

		function void restart();
			ph          = PH_SIZE;
			remaining   = '0;
			trailer_len = 0;
			clear_line();
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// one non-LF character of a size line
		function void take_size_char(logic [7:0] c);
			int v;
			int sum;
			if (in_ext)
				return;
			if (c == CH_SEMI) begin
				in_ext = 1'b1;
				return;
			end
			if (c == CH_SP || c == CH_TAB) begin
				if (digits != 0 && blanks < LEN_LIMIT)
					blanks++;
				return;
			end
			// blanks followed by more text: inner blanks, size is bad
			if (blanks != 0) begin
				sum    = digits + blanks;
				digits = (sum > LEN_LIMIT) ? LEN_LIMIT : sum;
				blanks = 0;
				bad    = 1'b1;
			end
			if (digits < LEN_LIMIT)
				digits++;
			v = 16;
			if (c >= CH_0 && c <= CH_9)
				v = c - CH_0;
			else if (c >= CH_LA && c <= CH_LF_HI)
				v = HEX_TEN + (c - CH_LA);
			else if (c >= CH_UA && c <= CH_UF)
				v = HEX_TEN + (c - CH_UA);
			if (v > 15)
				bad = 1'b1;
			else if (!bad)
				accum = {accum[59:0], v[3:0]};
		endfunction

		function status_t close_size_line();
			status_t s;
			s = ST_BUSY;
			if (digits == 0)
				s = ST_EMPTY;
			else if (digits > MAX_SIZE_DIGITS)
				s = ST_TOO_LONG;
			else if (bad)
				s = ST_BAD_HEX;
			else if (accum == 0) begin
				ph          = PH_TRAILER;
				trailer_len = 0;
			end else begin
				ph        = PH_DATA;
				remaining = accum;
			end
			clear_line();
			return s;
		endfunction

		function status_t end_status(phase_t p);
			case (p) inside
				PH_SIZE:                  return ST_NO_SIZE;
				PH_DATA:                  return ST_PAST_END;
				PH_AFTER_DATA, PH_AFTER_CR: return ST_NO_TERM;
				PH_TRAILER:               return ST_NO_TRAILER;
				default:                  return ST_BUSY;
			endcase
		endfunction

		function void note_byte(logic [7:0] c, logic last);
			beat_t   w;
			status_t s;
			bit      line_done;
			w.pbyte   = '0;
			w.pvalid  = 1'b0;
			s         = ST_BUSY;
			line_done = 1'b0;
			case (ph)
				PH_SIZE: begin
					if (cr_held) begin
						cr_held = 1'b0;
						if (c == CH_LF) begin
							s         = close_size_line();
							line_done = 1'b1;
						end else
							take_size_char(CH_CR);
					end
					if (!line_done) begin
						if (c == CH_CR)
							cr_held = 1'b1;
						else if (c == CH_LF)
							s = close_size_line();
						else
							take_size_char(c);
					end
				end
				PH_DATA: begin
					w.pbyte  = c;
					w.pvalid = 1'b1;
					remaining--;
					if (remaining == 0)
						ph = PH_AFTER_DATA;
				end
				PH_AFTER_DATA: begin
					if (c == CH_CR)
						ph = PH_AFTER_CR;
					else if (c == CH_LF)
						ph = PH_SIZE;
					else
						s = ST_NO_TERM;
				end
				PH_AFTER_CR: begin
					if (c == CH_LF)
						ph = PH_SIZE;
					else
						s = ST_NO_TERM;
				end
				PH_TRAILER: begin
					if (c == CH_LF) begin
						if (trailer_len <= 1)
							s = ST_DONE;
						trailer_len = 0;
					end else if (c == CH_CR && trailer_len == 0)
						trailer_len = 1;
					else
						trailer_len = 2;
				end
				default: ;
			endcase
			if (s == ST_BUSY && last)
				s = end_status(ph);
			if (last)
				restart();
			else if (s != ST_BUSY)
				ph = PH_SKIP;
			w.st = s;
			owed_q = {owed_q, w};
		endfunction

		function void check_beat(logic [7:0] pbyte, logic pvalid, logic [3:0] st);
			beat_t w;
			if (owed_q.size() == 0) begin
				$error("result beat with nothing owed: byte %h valid %b status %0d",
					pbyte, pvalid, st);
				errors++;
				return;
			end
			w = owed_q.pop_front();
			if (pbyte !== w.pbyte) begin
				$error("payload_byte: expected %h, actual %h", w.pbyte, pbyte);
				errors++;
			end
			if (pvalid !== w.pvalid) begin
				$error("payload_valid: expected %b, actual %b", w.pvalid, pvalid);
				errors++;
			end
			if (st !== w.st) begin
				$error("status: expected %0d, actual %0d", w.st, st);
				errors++;
			end
		endfunction

	endclass

endpackage

// ----- dv/tb_http_chunked_body_decoder.sv -----
module tb_http_chunked_body_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	import hcbd_pkg::*;
	import chunk_scoreboard_pkg::*;

	// no new body starts after this many input beats; the idle-free tail starts at QUIET_AT
	localparam int ITEMS     = 550;
	localparam int QUIET_AT  = 470;
	// worst case per beat: idle burst + stall burst + pipeline; this is many times that
	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN      = 10;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       last_of_input;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic [3:0] status;

	chunk_scoreboard sb;

	// idle knobs, one per side; quiet, shared by both sides, turns all idling off
	int  in_idle_pct;
	int  out_idle_pct;
	bit  quiet;
	int  stall_left;
	int  bytes_sent;
	int  cycles;

	// bytes of the body being built, last_of_input goes on the final one
	logic [7:0] body_q[$];

	http_chunked_body_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.last_of_input(last_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		while (cycles < MAX_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Result side: check each accepted result beat against the oldest owed one,
	// then pick the stall for the next cycle. Values read here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(payload_byte, payload_valid, status);
		if (quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < out_idle_pct) begin
			// start a stall burst of random length, counted down in stall_left
			stall_left = $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// Byte biased toward the characters that steer the parser.
	function automatic logic [7:0] junk_byte();
		case ($urandom_range(0, 7))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_SEMI;
			3: return CH_SP;
			4: return CH_TAB;
			5: return CH_0 + 8'($urandom_range(0, 9));
			6: return CH_UA + 8'($urandom_range(0, 7));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		body_q = {body_q, b};
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// LF alone or CR LF
	task automatic add_eol(input bit crlf);
		if (crlf)
			add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	// Size line: optional blanks around the digits, mixed-case hex, leading zeros
	// now and then out to the digit limit and past it, optional extension.
	task automatic add_size_line(input logic [63:0] val);
		int         ndig;
		logic [3:0] nib;
		ndig = 1;
		while (ndig < 16 && (val >> (4 * ndig)) != 0)
			ndig++;
		if ($urandom_range(0, 9) == 0)
			ndig = $urandom_range(ndig > 15 ? ndig : 15, 18);
		else
			ndig += $urandom_range(0, 1) * $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
		for (int i = ndig - 1; i >= 0; i--) begin
			nib = (i < 16) ? val[i*4 +: 4] : 4'h0;
			if (nib < 10)
				add_byte(CH_0 + nib);
			else
				add_byte(($urandom_range(0, 1) ? CH_UA : CH_LA) + nib - HEX_TEN);
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
		if ($urandom_range(0, 4) == 0) begin
			add_byte(CH_SEMI);
			repeat ($urandom_range(0, 4))
				add_byte($urandom_range(0, 3) == 0 ? CH_CR
					: 8'h61 + 8'($urandom_range(0, 25)));
		end
		add_eol(1'($urandom_range(0, 1)));
	endtask

	// One input beat: optional idle burst, then hold the beat until it is taken.
	// in_valid only gets one nonblocking write per time step.
	task automatic push_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < in_idle_pct)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		last_of_input <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, l);
		bytes_sent++;
	endtask

	task automatic send_body();
		for (int i = 0; i < body_q.size(); i++)
			push_byte(body_q[i], i == body_q.size() - 1);
		body_q.delete();
	endtask

	initial begin
		int          mode;
		int          nchunks;
		int          csize;
		int          keep;
		logic [63:0] big;

		sb            = new();
		arst_n        = 1'b0;
		in_valid      <= 1'b0;
		in_byte       <= '0;
		last_of_input <= 1'b0;
		out_stall     <= 1'b0;
		in_idle_pct   = 20;
		out_idle_pct  = 20;
		quiet         = 1'b0;
		stall_left    = 0;
		bytes_sent    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed bodies ---
		// blanks trimmed around the size, CR LF but for a bare LF on the last size line,
		// data byte FF, extension on the last chunk, trailer ends on a line holding one CR
		add_str(" 1");
		add_byte(CH_TAB);
		add_eol(1);
		add_byte(8'hFF);
		add_eol(1);
		add_str("0;q");
		add_eol(0);
		add_eol(1);
		send_body();
		// empty size line, last beat right on the LF
		add_eol(0);
		send_body();
		// lone CR inside the size text is a bad digit; later bytes skipped
		add_str("1");
		add_byte(CH_CR);
		add_str("2");
		add_eol(0);
		add_str("z");
		send_body();
		// blank between digits
		add_str("a b");
		add_eol(0);
		send_body();
		// input ends in chunk data: data byte 00 still passed out
		add_str("2");
		add_eol(0);
		add_byte(8'h00);
		send_body();
		// input ends between data and its LF
		add_str("A");
		add_eol(0);
		add_str("0123456789");
		add_byte(CH_CR);
		send_body();
		// input ends inside the trailer, then inside a size line
		add_str("0");
		add_eol(0);
		add_str("x");
		send_body();
		add_str("f");
		send_body();

		// --- random bodies ---
		while (bytes_sent < ITEMS) begin
			quiet = (bytes_sent >= QUIET_AT);
			case ($urandom_range(0, 3))
				0: in_idle_pct = 0;
				1: in_idle_pct = 5;
				2: in_idle_pct = 20;
				default: in_idle_pct = 50;
			endcase
			case ($urandom_range(0, 3))
				0: out_idle_pct = 0;
				1: out_idle_pct = 5;
				2: out_idle_pct = 20;
				default: out_idle_pct = 40;
			endcase
			mode = $urandom_range(0, 99);
			if (mode < 8) begin
				// pure noise
				repeat ($urandom_range(1, 12))
					add_byte(junk_byte());
			end else if (mode < 12) begin
				// huge size, input runs out in the data
				big = {$urandom(), $urandom()};
				add_size_line(big);
				repeat ($urandom_range(0, 4))
					add_byte(8'($urandom_range(0, 255)));
			end else begin
				// well-formed body with random content
				nchunks = $urandom_range(0, 3);
				repeat (nchunks) begin
					csize = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
						: $urandom_range(1, 6);
					add_size_line(64'(csize));
					repeat (csize)
						add_byte(8'($urandom_range(0, 255)));
					add_eol(1'($urandom_range(0, 1)));
				end
				add_size_line(64'd0);
				repeat ($urandom_range(0, 2)) begin
					if ($urandom_range(0, 1))
						add_str("x-k: v");
					else
						add_str("e:");
					add_eol(1'($urandom_range(0, 1)));
				end
				add_eol(1'($urandom_range(0, 1)));
				if (mode < 24) begin
					// one byte knocked out
					body_q[$urandom_range(0, body_q.size() - 1)] = junk_byte();
				end else if (mode < 36) begin
					// input cut short
					keep = $urandom_range(1, body_q.size());
					while (body_q.size() > keep)
						void'(body_q.pop_back());
				end else if (mode < 44) begin
					// bytes after the end, ignored until the last one
					repeat ($urandom_range(1, 5))
						add_byte(junk_byte());
				end
			end
			send_body();
		end
		in_valid <= 1'b0;

		// drain: everything owed must arrive, then stay quiet a little longer
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_front.sv
hdl/hcbd_queue.sv
hdl/hcbd_back.sv
hdl/http_chunked_body_decoder.sv
hdl/hcbd_checker.sv
dv/chunk_scoreboard_pkg.sv
dv/tb_http_chunked_body_decoder.sv
